// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared item types, result kinds and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OPCODE_W = 4;
	localparam int unsigned LENGTH_W = 64;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned HCOUNT_W = 4;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [HCOUNT_W-1:0] EXT16_BYTES = 4'd2;
	localparam logic [HCOUNT_W-1:0] EXT64_BYTES = 4'd8;
	localparam logic [HCOUNT_W-1:0] MASK_BYTES  = 4'd4;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
	} stream_item_t;

	typedef struct packed {
		logic                result_kind;
		logic                final_fragment;
		logic [OPCODE_W-1:0] frame_opcode;
		logic                was_masked;
		logic [LENGTH_W-1:0] payload_length;
		logic [BYTE_W-1:0]   payload_byte;
		logic                frame_end;
	} result_item_t;

	typedef struct packed {
		logic         valid;
		result_item_t item;
	} parse_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/wsd_ifs.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Valid/ready channels for raw stream beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_stream_if;
	import wsd_pkg::*;

	logic         valid;
	logic         ready;
	stream_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wsd_result_if;
	import wsd_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Frame header state machine and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [wsd_pkg::BYTE_W-1:0]  stream_byte,
	output wsd_pkg::parse_out_t              res
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_B0      = 3'd0,
		PH_B1      = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	phase_t              phase_q, phase_n;
	logic                fin_q, fin_n;
	logic [OPCODE_W-1:0] opcode_q, opcode_n;
	logic                mask_q, mask_n;
	logic [LENGTH_W-1:0] len_q, len_n;
	logic [HCOUNT_W-1:0] cnt_q, cnt_n;
	logic [KEY_W-1:0]    key_q, key_n;
	logic [LENGTH_W-1:0] rem_q, rem_n;
	logic [1:0]          kidx_q, kidx_n;

	logic                len_done;
	logic                hdr_done;
	logic                last;
	logic                empty;
	logic [BYTE_W-1:0]   key_byte;

	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		mask_n   = mask_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		key_n    = key_q;
		rem_n    = rem_q;
		kidx_n   = kidx_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		empty    = 1'b0;
		last     = (rem_q == LENGTH_W'(1));
		key_byte = key_q[{~kidx_q, 3'b000} +: BYTE_W];
		res      = '0;

		unique case (phase_q)
			PH_B1: begin
				mask_n = stream_byte[7];
				cnt_n  = '0;
				if (stream_byte[6:0] == LEN7_EXT16) begin
					len_n   = '0;
					phase_n = PH_EXT16;
				end else if (stream_byte[6:0] == LEN7_EXT64) begin
					len_n   = '0;
					phase_n = PH_EXT64;
				end else begin
					len_n    = LENGTH_W'(stream_byte[6:0]);
					len_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_n = {len_q[LENGTH_W-BYTE_W-1:0], stream_byte};
				cnt_n = cnt_q + HCOUNT_W'(1);
				if (cnt_n == ((phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
					len_done = 1'b1;
			end
			PH_MASK: begin
				key_n = {key_q[KEY_W-BYTE_W-1:0], stream_byte};
				cnt_n = cnt_q + HCOUNT_W'(1);
				if (cnt_n == MASK_BYTES)
					hdr_done = 1'b1;
			end
			PH_PAYLOAD: begin
				res.valid               = 1'b1;
				res.item.result_kind    = KIND_PAYLOAD;
				res.item.payload_byte   = stream_byte ^ key_byte;
				res.item.frame_end      = last;
				if (last) begin
					phase_n = PH_B0;
					kidx_n  = '0;
				end else begin
					kidx_n  = kidx_q + 2'd1;
				end
				rem_n = rem_q - LENGTH_W'(1);
			end
			default: begin
				fin_n    = stream_byte[7];
				opcode_n = stream_byte[OPCODE_W-1:0];
				phase_n  = PH_B1;
			end
		endcase

		if (len_done) begin
			cnt_n = '0;
			if (mask_n)
				phase_n = PH_MASK;
			else
				hdr_done = 1'b1;
		end

		if (hdr_done) begin
			empty  = (len_n == '0);
			if (!mask_n)
				key_n = '0;
			rem_n   = len_n;
			kidx_n  = '0;
			cnt_n   = '0;
			phase_n = empty ? PH_B0 : PH_PAYLOAD;
			res.valid             = 1'b1;
			res.item.result_kind  = KIND_HEADER;
			res.item.payload_byte = '0;
			res.item.frame_end    = empty;
		end

		res.item.final_fragment = fin_n;
		res.item.frame_opcode   = opcode_n;
		res.item.was_masked     = mask_n;
		res.item.payload_length = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_B0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			key_q    <= '0;
			rem_q    <= '0;
			kidx_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			len_q    <= len_n;
			cnt_q    <= cnt_n;
			key_q    <= key_n;
			rem_q    <= rem_n;
			kidx_q   <= kidx_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a raw WebSocket byte stream into header results and unmasked
// payload byte results.
//
// Channels: stream carries one raw frame byte per beat; result carries one
// header or payload result per beat. Both use valid/ready, a beat moves on a
// rising clk edge with valid and ready high.
// Header bytes other than the one that completes a header give no result.
// A byte is held in an input register, parsed by the header state machine
// and captured in the result register; the result is offered from that
// register, and the byte is parsed only once the result register is free.
// Throughput is one byte per cycle, set by the single parse step between the
// input and result registers; stream stays ready while result is taken.
// When result stalls, the result register holds and one byte waits in the
// input register; stream ready drops until the result beat is taken.
// arst_n clears both valid flags and returns the parser to await the first
// header byte of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wsd_stream_if.sink  stream,
	wsd_result_if.source result
);
	import wsd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_item_t      out_q;
	logic              out_free;
	logic              advance;
	parse_out_t        pres;

	assign out_free     = !out_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.stream_byte (byte_s1),
		.res         (pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (stream.valid && stream.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (out_free)
				out_valid_q <= advance && pres.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready)
			byte_s1 <= stream.data.stream_byte;
		if (advance && pres.valid)
			out_q <= pres.item;
	end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds raw frame bytes into the stream channel: a fixed table first, then
// random frames with random header forms, mask keys and payloads, mixed with
// bursts of random bytes with tamed length fields. Each accepted byte runs
// through a behavioral copy of the parser and every result beat is compared
// field by field with the oldest prediction, under several source and sink
// idle patterns. The run ends on a frame whose 64-bit length has every bit set.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	typedef enum logic [2:0] {
		ST_FIRST   = 3'd0,
		ST_SECOND  = 3'd1,
		ST_LEN16   = 3'd2,
		ST_LEN64   = 3'd3,
		ST_KEY     = 3'd4,
		ST_DATA    = 3'd5
	} hdr_phase_t;

	typedef struct {
		logic [7:0]   b;
		bit           typed;
		result_item_t res;
	} stim_row_t;

	localparam result_item_t NO_RESULT = '0;
	localparam int           HOLD_CYCLES = 300;
	localparam int           PHASE_BYTES = 400;

	logic clk;
	logic arst_n;

	wsd_stream_if stream_ch ();
	wsd_result_if result_ch ();

	websocket_frame_deframer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	hdr_phase_t    ph         = ST_FIRST;
	logic          cur_fin    = 1'b0;
	logic [3:0]    cur_op     = '0;
	logic          cur_masked = 1'b0;
	logic [63:0]   cur_len    = '0;
	logic [3:0]    hdr_cnt    = '0;
	logic [31:0]   key        = '0;
	logic [63:0]   pidx       = '0;

	result_item_t  exp_q[$];
	int            err_cnt      = 0;
	int            fed          = 0;
	int            src_idle_pct = 0;
	int            snk_stall_pct = 0;
	bit            hold_req     = 1'b0;

	function automatic result_item_t mk_result(logic kind, logic fin, logic [3:0] op,
			logic masked, logic [63:0] len, logic [7:0] pbyte, logic fend);
		result_item_t r;
		r.result_kind    = kind;
		r.final_fragment = fin;
		r.frame_opcode   = op;
		r.was_masked     = masked;
		r.payload_length = len;
		r.payload_byte   = pbyte;
		r.frame_end      = fend;
		return r;
	endfunction

	function automatic bit header_done(output result_item_t r);
		if (!cur_masked)
			key = '0;
		pidx    = '0;
		hdr_cnt = '0;
		ph      = (cur_len == 64'd0) ? ST_FIRST : ST_DATA;
		r = mk_result(KIND_HEADER, cur_fin, cur_op, cur_masked, cur_len, 8'h00,
			cur_len == 64'd0);
		return 1'b1;
	endfunction

	function automatic bit length_done(output result_item_t r);
		hdr_cnt = '0;
		r = NO_RESULT;
		if (cur_masked) begin
			ph = ST_KEY;
			return 1'b0;
		end
		return header_done(r);
	endfunction

	function automatic bit deframe(input logic [7:0] b, output result_item_t r);
		logic [7:0] k;
		logic       last;
		r = NO_RESULT;
		case (ph)
			ST_SECOND: begin
				cur_masked = b[7];
				hdr_cnt = '0;
				if (b[6:0] == LEN7_EXT16) begin
					cur_len = '0;
					ph = ST_LEN16;
					return 1'b0;
				end
				if (b[6:0] == LEN7_EXT64) begin
					cur_len = '0;
					ph = ST_LEN64;
					return 1'b0;
				end
				cur_len = {57'd0, b[6:0]};
				return length_done(r);
			end
			ST_LEN16, ST_LEN64: begin
				cur_len = {cur_len[55:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt != ((ph == ST_LEN16) ? EXT16_BYTES : EXT64_BYTES))
					return 1'b0;
				return length_done(r);
			end
			ST_KEY: begin
				key = {key[23:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt != MASK_BYTES)
					return 1'b0;
				return header_done(r);
			end
			ST_DATA: begin
				k = key[(3 - pidx[1:0]) * 8 +: 8];
				last = (pidx == cur_len - 64'd1);
				r = mk_result(KIND_PAYLOAD, cur_fin, cur_op, cur_masked, cur_len, b ^ k, last);
				if (last) begin
					ph = ST_FIRST;
					pidx = '0;
				end else begin
					pidx = pidx + 64'd1;
				end
				return 1'b1;
			end
			default: begin
				cur_fin = b[7];
				cur_op  = b[3:0];
				ph      = ST_SECOND;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void cmp_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			err_cnt++;
		end
	endfunction

	task automatic take_result(input result_item_t got);
		result_item_t e;
		if (exp_q.size() == 0) begin
			$error("result beat with nothing pending: %h", got);
			err_cnt++;
			return;
		end
		e = exp_q.pop_front();
		cmp_field("result_kind", 64'(e.result_kind), 64'(got.result_kind));
		cmp_field("final_fragment", 64'(e.final_fragment), 64'(got.final_fragment));
		cmp_field("frame_opcode", 64'(e.frame_opcode), 64'(got.frame_opcode));
		cmp_field("was_masked", 64'(e.was_masked), 64'(got.was_masked));
		cmp_field("payload_length", e.payload_length, got.payload_length);
		cmp_field("payload_byte", 64'(e.payload_byte), 64'(got.payload_byte));
		cmp_field("frame_end", 64'(e.frame_end), 64'(got.frame_end));
	endtask

	task automatic feed_byte(input logic [7:0] b, input bit typed, input result_item_t res);
		result_item_t pr;
		bit           has;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.data  <= '{stream_byte: b};
		do @(posedge clk); while (!stream_ch.ready);
		fed++;
		has = deframe(b, pr);
		if (typed)
			exp_q.push_back(res);
		else if (has)
			exp_q.push_back(pr);
	endtask

	function automatic logic [7:0] tame(input logic [7:0] b);
		if (ph == ST_LEN16 && hdr_cnt == 4'd0)
			return b & 8'h01;
		if (ph == ST_LEN64 && hdr_cnt < 4'd7)
			return 8'h00;
		return b;
	endfunction

	task automatic send_frame();
		logic [7:0]  b0;
		logic        masked;
		logic [63:0] len;
		logic [6:0]  len7;
		int          r;
		b0 = 8'($urandom_range(0, 255));
		masked = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 10)
			len = '0;
		else if (r < 75)
			len = 64'($urandom_range(1, 20));
		else if (r < 85)
			len = 64'($urandom_range(21, 125));
		else if (r < 95)
			len = 64'($urandom_range(0, 300));
		else
			len = 64'($urandom_range(0, 40));
		len7 = (r >= 95) ? LEN7_EXT64 : (r >= 85) ? LEN7_EXT16 : len[6:0];
		feed_byte(b0, 1'b0, NO_RESULT);
		feed_byte({masked, len7}, 1'b0, NO_RESULT);
		if (r >= 95) begin
			for (int i = 7; i >= 0; i--)
				feed_byte(len[8 * i +: 8], 1'b0, NO_RESULT);
		end else if (r >= 85) begin
			feed_byte(len[15:8], 1'b0, NO_RESULT);
			feed_byte(len[7:0], 1'b0, NO_RESULT);
		end
		if (masked)
			repeat (4) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
		repeat (len) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
	endtask

	task automatic send_garbage();
		repeat ($urandom_range(1, 10))
			feed_byte(tame(8'($urandom_range(0, 255))), 1'b0, NO_RESULT);
		while (ph != ST_FIRST)
			feed_byte(tame(8'($urandom_range(0, 255))), 1'b0, NO_RESULT);
	endtask

	task automatic drain();
		stream_ch.valid <= 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin : sink_side
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				take_result(result_ch.data);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	initial begin : source_side
		stim_row_t plan[$];
		int        src_pct[4];
		int        snk_pct[4];
		int        start;
		arst_n <= 1'b0;
		stream_ch.valid <= 1'b0;
		stream_ch.data  <= '0;
		src_pct = '{0, 78, 0, 32};
		snk_pct = '{0, 0, 78, 32};

		plan.push_back('{8'hFF, 1'b0, NO_RESULT});
		plan.push_back('{8'h00, 1'b1,
			mk_result(KIND_HEADER, 1'b1, 4'hF, 1'b0, 64'd0, 8'h00, 1'b1)});
		plan.push_back('{8'h02, 1'b0, NO_RESULT});
		plan.push_back('{8'hFE, 1'b0, NO_RESULT});
		plan.push_back('{8'h00, 1'b0, NO_RESULT});
		plan.push_back('{8'h03, 1'b0, NO_RESULT});
		plan.push_back('{8'hFF, 1'b0, NO_RESULT});
		plan.push_back('{8'h00, 1'b0, NO_RESULT});
		plan.push_back('{8'hA5, 1'b0, NO_RESULT});
		plan.push_back('{8'h5A, 1'b0, NO_RESULT});
		plan.push_back('{8'h00, 1'b0, NO_RESULT});
		plan.push_back('{8'hFF, 1'b0, NO_RESULT});
		plan.push_back('{8'h3C, 1'b0, NO_RESULT});
		plan.push_back('{8'h88, 1'b0, NO_RESULT});
		plan.push_back('{8'h7F, 1'b0, NO_RESULT});
		repeat (7) plan.push_back('{8'h00, 1'b0, NO_RESULT});
		plan.push_back('{8'h01, 1'b0, NO_RESULT});
		plan.push_back('{8'hAB, 1'b1,
			mk_result(KIND_PAYLOAD, 1'b1, 4'h8, 1'b0, 64'd1, 8'hAB, 1'b1)});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			feed_byte(plan[i].b, plan[i].typed, plan[i].res);
		drain();

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_pct[p];
			snk_stall_pct = snk_pct[p];
			if (p == 0)
				hold_req = 1'b1;
			start = fed;
			while (fed - start < PHASE_BYTES) begin
				if ($urandom_range(0, 99) < 85)
					send_frame();
				else
					send_garbage();
			end
			drain();
		end

		feed_byte(8'h82, 1'b0, NO_RESULT);
		feed_byte(8'hFF, 1'b0, NO_RESULT);
		repeat (8) feed_byte(8'hFF, 1'b0, NO_RESULT);
		repeat (34) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
		drain();

		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
